@@ design/prime_test_trial_division_top_macros.svh @@
// assertion macros for the trial division primality tester
`ifndef PRIME_TEST_TRIAL_DIVISION_TOP_MACROS_SVH
`define PRIME_TEST_TRIAL_DIVISION_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PTD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ptd_pkg.sv @@
// package with widths, constants and sequencer states of the primality tester
package ptd_pkg;

    localparam int CAND_W = 32;
    localparam int VAL_W  = 31;
    localparam int DIV_W  = 16;
    localparam int SQ_W   = 32;
    localparam int ALU_W  = 33;
    localparam int BIT_W  = 5;

    localparam logic [DIV_W-1:0] FIRST_DIV = 16'd3;
    localparam logic [SQ_W-1:0]  FIRST_SQ  = 32'd9;
    localparam logic [BIT_W-1:0] TOP_BIT   = 5'd30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_BUMP,
        ST_FINISH
    } ptd_state_t;

endpackage

@@ design/ptd_ifs.sv @@
// valid/ready stream interfaces for candidates and prime flags
interface ptd_cand_if
    import ptd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [CAND_W-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface ptd_flag_if;
    logic valid;
    logic ready;
    logic prime_flag;

    modport source (output valid, output prime_flag, input ready);
    modport sink   (input valid, input prime_flag, output ready);
endinterface

@@ design/prime_test_trial_division_top.sv @@
// trial division primality tester with one shared add/compare unit
//
//   channel | role   | payload
//   --------+--------+------------------------------
//   req     | sink   | candidate, 32 bit signed
//   rsp     | source | prime_flag, 1 bit
//
// negative values, values below 4 and even values go from the transfer straight to the finish state
// every odd divisor runs a square compare, a bit-serial remainder over the 31 value bits, then a square update
// worst case is about 23170 divisors, each with its bit-serial remainder
// req.ready is high only while the sequencer is idle; a held result does not block it
// a finished item waits in the sequencer while the previous result is still not taken
// rst_n clears the sequencer and the output valid flag asynchronously
`include "prime_test_trial_division_top_macros.svh"

module prime_test_trial_division_top
    import ptd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ptd_cand_if.sink   req,
    ptd_flag_if.source rsp
);

    ptd_state_t       state_reg, state_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             result_reg, result_next;
    logic             out_valid_reg, out_valid_next;
    logic             flag_reg, flag_next;

    // shared adder
    logic [ALU_W-1:0] alu_a, alu_b;
    logic             alu_cin;
    logic [ALU_W:0]   alu_sum;
    logic             alu_carry;

    logic [DIV_W:0]   rem_shift;
    logic [DIV_W:0]   d_plus1;
    logic             accept;
    logic             out_free;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rem_shift = {rem_reg, value_reg[bit_reg]};
    assign d_plus1   = {1'b0, d_reg} + {{DIV_W{1'b0}}, 1'b1};

    // operand select for the shared adder
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        unique case (state_reg)
            ST_TEST:
            begin
                // value - sq, carry set when sq <= value
                alu_a   = {{(ALU_W-VAL_W){1'b0}}, value_reg};
                alu_b   = ~{{(ALU_W-SQ_W){1'b0}}, sq_reg};
                alu_cin = 1'b1;
            end
            ST_DIV:
            begin
                // partial remainder - d, carry set when no borrow
                alu_a   = {{(ALU_W-DIV_W-1){1'b0}}, rem_shift};
                alu_b   = ~{{(ALU_W-DIV_W){1'b0}}, d_reg};
                alu_cin = 1'b1;
            end
            ST_BUMP:
            begin
                // (d+2)^2 = d^2 + 4(d+1)
                alu_a   = {{(ALU_W-SQ_W){1'b0}}, sq_reg};
                alu_b   = {{(ALU_W-DIV_W-3){1'b0}}, d_plus1, 2'b00};
                alu_cin = 1'b0;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_cin = 1'b0;
            end
        endcase
    end

    assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b} + {{ALU_W{1'b0}}, alu_cin};
    assign alu_carry = alu_sum[ALU_W];

    // remainder step result
    always_comb
    begin
        if (alu_carry)
        begin
            rem_next = alu_sum[DIV_W-1:0];
        end
        else
        begin
            rem_next = rem_shift[DIV_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (req.candidate[CAND_W-1] ||
                                 req.candidate[VAL_W-1:0] < 31'd4 ||
                                 !req.candidate[0])
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_TEST;
                    end
                end
            end
            ST_TEST:
            begin
                state_next = alu_carry ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                if (bit_reg == '0)
                begin
                    state_next = (rem_next == '0) ? ST_FINISH : ST_BUMP;
                end
            end
            ST_BUMP:
            begin
                state_next = ST_TEST;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output register updates
    always_comb
    begin
        value_next     = value_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        bit_next       = bit_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        flag_next      = flag_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_next = req.candidate[VAL_W-1:0];
                    d_next     = FIRST_DIV;
                    sq_next    = FIRST_SQ;
                    priority if (req.candidate[CAND_W-1] ||
                                 req.candidate[VAL_W-1:0] < 31'd2)
                    begin
                        result_next = 1'b0;
                    end
                    else if (req.candidate[VAL_W-1:0] < 31'd4)
                    begin
                        result_next = 1'b1;
                    end
                    else
                    begin
                        result_next = req.candidate[0];
                    end
                end
            end
            ST_TEST:
            begin
                // square above value means no divisor left
                bit_next    = TOP_BIT;
                result_next = 1'b1;
            end
            ST_DIV:
            begin
                bit_next = bit_reg - 5'd1;
                if (bit_reg == '0 && rem_next == '0)
                begin
                    result_next = 1'b0;
                end
            end
            ST_BUMP:
            begin
                sq_next = alu_sum[SQ_W-1:0];
                d_next  = d_plus1[DIV_W-1:0] + 16'd1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    flag_next      = result_reg;
                end
            end
            default:
            begin
                bit_next = bit_reg;
            end
        endcase
    end

    // remainder clears before each new divisor
    logic [DIV_W-1:0] rem_load;
    assign rem_load = (state_reg == ST_DIV) ? rem_next : '0;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        d_reg      <= d_next;
        sq_reg     <= sq_next;
        rem_reg    <= rem_load;
        bit_reg    <= bit_next;
        result_reg <= result_next;
        flag_reg   <= flag_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.prime_flag = flag_reg;

    // conditions used by the checks
    logic chk_div;
    logic chk_loop;
    logic chk_even;
    logic done_zero;
    assign chk_div   = (state_reg == ST_DIV);
    assign chk_loop  = (state_reg == ST_TEST) || (state_reg == ST_BUMP);
    assign chk_even  = accept && !req.candidate[CAND_W-1] &&
                       (req.candidate[VAL_W-1:0] > 31'd3) && !req.candidate[0];
    assign done_zero = (state_reg == ST_FINISH) && !result_reg;

    // checks on the sequencer
    `PTD_ASSERT_SAME(a_rem_below_div, chk_div, rem_reg < d_reg, "remainder not below divisor")
    `PTD_ASSERT_SAME(a_div_odd, chk_loop, d_reg[0], "even trial divisor")
    `PTD_ASSERT_NEXT(a_even_fast, chk_even, done_zero, "even candidate not rejected at once")

endmodule

@@ bench/prime_test_trial_division_top_tb.sv @@
// self-checking testbench for the trial division primality tester
module prime_test_trial_division_top_tb;
    import ptd_pkg::*;

    localparam int unsigned RAND_ITEMS  = 77;
    localparam int unsigned STALL_LIMIT = 3000000;
    localparam int unsigned TAIL_CYCLES = 64;
    localparam int unsigned HOLD_AT     = 2;
    localparam int unsigned HOLD_LEN    = 500;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        logic signed [CAND_W-1:0] candidate;
        logic                     prime_flag;
    } flag_expect_t;

    logic clk = 1'b0;
    logic rst_n;

    ptd_cand_if req_if ();
    ptd_flag_if rsp_if ();

    prime_test_trial_division_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic signed [CAND_W-1:0] cand_pend_q[$];
    flag_expect_t             flag_expect_q[$];

    int unsigned sent_cnt = 0;
    int unsigned seen_cnt = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned stall_cycles;
    int unsigned send_gap;
    int unsigned take_gap;
    int unsigned hold_left;
    logic        hold_done;

    // primality by odd trial divisors, squared bound kept exact in 64 bits
    function automatic logic predict_prime(logic signed [CAND_W-1:0] cand);
        logic [63:0] value;
        logic [63:0] div;
        if (cand < 0)
            return 1'b0;
        value = {33'd0, cand[VAL_W-1:0]};
        if (value < 64'd2)
            return 1'b0;
        if (value < 64'd4)
            return 1'b1;
        if (!value[0])
            return 1'b0;
        for (div = 64'd3; div * div <= value; div += 64'd2)
        begin
            if (value % div == 64'd0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // per-item wait, with bursts of back-to-back transfers
    function automatic int unsigned draw_gap(int unsigned n);
        if ((n / 16) % 3 == 2)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    // append one candidate to the pending queue
    task automatic add_cand(logic signed [CAND_W-1:0] cand);
        cand_pend_q = {cand_pend_q, cand};
    endtask

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // candidate driver
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned              gap;
        logic                     next_valid;
        logic signed [CAND_W-1:0] next_cand;
        flag_expect_t             exp_item;
        if (!rst_n)
        begin
            req_if.valid     <= 1'b0;
            req_if.candidate <= '0;
            send_gap         <= 0;
        end
        else
        begin
            gap        = send_gap;
            next_valid = req_if.valid;
            next_cand  = req_if.candidate;
            // transfer accepted: record the expected flag
            if (req_if.valid && req_if.ready)
            begin
                exp_item.candidate  = req_if.candidate;
                exp_item.prime_flag = predict_prime(req_if.candidate);
                flag_expect_q       = {flag_expect_q, exp_item};
                sent_cnt++;
                next_valid = 1'b0;
                gap        = draw_gap(sent_cnt);
            end
            // offer the next pending candidate once the gap runs out
            if (!next_valid)
            begin
                if (gap != 0)
                    gap--;
                else if (cand_pend_q.size() != 0)
                begin
                    next_valid = 1'b1;
                    next_cand  = cand_pend_q.pop_front();
                end
            end
            req_if.valid     <= next_valid;
            req_if.candidate <= next_cand;
            send_gap         <= gap;
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && seen_cnt == HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // flag monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned  gap;
        flag_expect_t exp_item;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            take_gap     <= 0;
        end
        else
        begin
            gap = take_gap;
            if (rsp_if.valid && rsp_if.ready)
            begin
                seen_cnt++;
                if (flag_expect_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("unexpected flag %0b with no candidate pending",
                                 rsp_if.prime_flag);
                end
                else
                begin
                    exp_item = flag_expect_q.pop_front();
                    if (rsp_if.prime_flag !== exp_item.prime_flag)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display("candidate %0d: prime_flag expected %0b, actual %0b",
                                     exp_item.candidate, exp_item.prime_flag,
                                     rsp_if.prime_flag);
                    end
                end
                gap = draw_gap(seen_cnt);
            end
            else if (gap != 0)
                gap--;
            rsp_if.ready <= (gap == 0) && (hold_left == 0);
            take_gap     <= gap;
        end
    end

    // cycles without any transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // stimulus, reset and end of run
    initial
    begin
        int unsigned              sel;
        int unsigned              pick;
        int unsigned              factor;
        int unsigned              mult;
        logic signed [CAND_W-1:0] cand;
        int unsigned              small_primes[9];

        small_primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23};
        rst_n        = 1'b0;

        // directed: negatives, values below two, small primes, squares, extremes
        add_cand(32'sh8000_0000);
        add_cand(-32'sd1);
        add_cand(32'sd0);
        add_cand(32'sd1);
        add_cand(32'sd2);
        add_cand(32'sd3);
        add_cand(32'sd4);
        add_cand(32'sd5);
        add_cand(32'sd9);
        add_cand(32'sd25);
        add_cand(32'sd49);
        add_cand(32'sd97);
        add_cand(32'sd121);
        add_cand(32'sd63001);
        add_cand(32'sd64507);
        add_cand(32'sd65521);
        add_cand(32'sd65537);
        add_cand(32'sd1000003);
        add_cand(32'sh5555_5555);
        add_cand(32'shAAAA_AAAA);
        add_cand(32'sh7FFF_FFFE);
        add_cand(32'sh7FFF_FFFD);
        add_cand(32'sh7FFF_FFFF);

        // random: small and negative values, full-width composites with small factors, mid-range values
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 50)
                cand = $urandom_range(0, 5000);
            else if (sel < 65)
                cand = {1'b1, 31'($urandom)};
            else if (sel < 90)
            begin
                pick   = $urandom_range(0, 8);
                factor = small_primes[pick];
                mult   = $urandom_range(1, 32'h7FFF_FFFF / factor);
                cand   = factor * mult;
            end
            else
                cand = $urandom_range(5000, 200000);
            add_cand(cand);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // drain: everything offered, accepted and answered
        @(negedge clk);
        while ((cand_pend_q.size() != 0 || req_if.valid || flag_expect_q.size() != 0)
               && stall_cycles < STALL_LIMIT)
            @(negedge clk);

        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("prime_test_trial_division_top: mismatch");
            $finish;
        end
        else
        begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (mismatch_cnt == 0 && flag_expect_q.size() == 0)
                $display("prime_test_trial_division_top: match");
            else
                $display("prime_test_trial_division_top: mismatch");
            $finish;
        end
    end

endmodule
